@@ rtl/bq128_pkg.sv @@
// ----------------------------------------------------------------------------
// bq128_pkg
// Shared types and constants for the binary128 multiplier pipeline.
// ----------------------------------------------------------------------------
package bq128_pkg;

  localparam int unsigned MANT_W = 113;   // significand with hidden bit
  localparam int unsigned PROD_W = 226;   // exact significand product
  localparam int unsigned EXP_W  = 18;    // signed internal exponent

  localparam logic [14:0]             EXP_MAX    = 15'h7FFF;
  localparam logic signed [EXP_W-1:0] EXP_BIAS_S = 18'sd16383;
  localparam logic signed [EXP_W-1:0] EXP_MIN_S  = -18'sd16382;

  // Rounding modes as held in the configuration register
  typedef enum logic [1:0] {
    RM_RNE = 2'd0,
    RM_RTZ = 2'd1,
    RM_RUP = 2'd2,
    RM_RDN = 2'd3
  } rmode_e;

  // Side information that travels with each item down the pipeline
  typedef struct packed {
    logic        special;   // result fully decided by the operand classes
    logic [63:0] hi;
    logic [63:0] lo;
    logic        inv;
    logic        sign;
  } ctl_t;

  // Normalized operands handed to the multiplier
  typedef struct packed {
    ctl_t                    ctl;
    logic [MANT_W-1:0]       ma;
    logic [MANT_W-1:0]       mb;
    logic signed [EXP_W-1:0] e;
  } op_t;

  // Finished result
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        inv;
    logic        ovf;
    logic        unf;
    logic        inx;
  } res_t;

  // Round increment decision for one rounding position
  function automatic logic round_inc(rmode_e mode, logic sign, logic rbit,
                                     logic sticky, logic lsb);
    logic r;
    case (mode)
      RM_RNE:  r = rbit && (sticky || lsb);
      RM_RTZ:  r = 1'b0;
      RM_RUP:  r = (rbit || sticky) && !sign;
      RM_RDN:  r = (rbit || sticky) && sign;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/binary128_multiplier_top.sv @@
// ----------------------------------------------------------------------------
// binary128_multiplier_top
// IEEE 754 binary128 multiplier, ten-stage pipeline, one product per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Multiplies two binary128 operands, each given as high and low 64-bit words,
// and returns the rounded product with invalid, overflow, underflow and
// inexact flags. Rounding follows the rounding mode register (nearest even,
// toward zero, toward plus infinity, toward minus infinity); write it over
// the configuration channel while no beat is in flight. Subnormal operands
// are normalized, subnormal results are rounded at the subnormal quantum, and
// tininess is detected after rounding. NaNs come back quieted, the first
// operand's NaN winning; infinity times zero gives the default quiet NaN.
// The block takes a new beat every cycle while the output is not stalled; two
// stages unpack and normalize, five run the 113x113 significand multiply
// (sixteen 32x32 partial products and a four-level adder tree), and three
// round and pack. Each stage has its own valid bit and loads whenever it is
// empty or the stage after it moves, so a stall at the output holds only the
// beats behind it and bubbles are squeezed out.
// ----------------------------------------------------------------------------
module binary128_multiplier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_rounding_mode_i,
  // operand channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] x_hi_i,
  input  logic [63:0] x_lo_i,
  input  logic [63:0] y_hi_i,
  input  logic [63:0] y_lo_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] product_hi_o,
  output logic [63:0] product_lo_o,
  output logic        flag_invalid_o,
  output logic        flag_overflow_o,
  output logic        flag_underflow_o,
  output logic        flag_inexact_o
);
  import bq128_pkg::*;

  localparam int unsigned NSTAGE = 10;

  rmode_e rounding_mode_q;

  logic [NSTAGE-1:0] valid_q, valid_d;
  logic [NSTAGE:0]   en;

  op_t                     op;
  logic [PROD_W-1:0]       prod;
  ctl_t                    mul_ctl;
  logic signed [EXP_W-1:0] mul_e;
  res_t                    res;

  // Rounding mode register: always ready, write takes effect next cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounding_mode_q <= RM_RNE;
    end else if (cfg_valid_i) begin
      rounding_mode_q <= rmode_e'(cfg_rounding_mode_i);
    end
  end

  // Stage enables: a stage advances when it is empty or the next one advances
  always_comb begin
    en[NSTAGE] = out_ready_i;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // Valid bits ride along with the data
  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NSTAGE-1];

  // Stages 0..1: classify, normalize, exponent sum
  bq128_unpack u_unpack (
    .clk_i  (clk_i),
    .en_i   (en[1:0]),
    .x_hi_i (x_hi_i),
    .x_lo_i (x_lo_i),
    .y_hi_i (y_hi_i),
    .y_lo_i (y_lo_i),
    .op_o   (op)
  );

  // Stages 2..6: significand product
  bq128_mant_mul u_mant_mul (
    .clk_i  (clk_i),
    .en_i   (en[6:2]),
    .op_i   (op),
    .prod_o (prod),
    .ctl_o  (mul_ctl),
    .e_o    (mul_e)
  );

  // Stages 7..9: round and pack; the last stage is the output register
  bq128_round u_round (
    .clk_i  (clk_i),
    .en_i   (en[9:7]),
    .mode_i (rounding_mode_q),
    .prod_i (prod),
    .ctl_i  (mul_ctl),
    .e_i    (mul_e),
    .res_o  (res)
  );

  assign product_hi_o     = res.hi;
  assign product_lo_o     = res.lo;
  assign flag_invalid_o   = res.inv;
  assign flag_overflow_o  = res.ovf;
  assign flag_underflow_o = res.unf;
  assign flag_inexact_o   = res.inx;

endmodule

@@ rtl/bq128_unpack.sv @@
// ----------------------------------------------------------------------------
// bq128_unpack
// Two stages: classify operands and settle special results, then
// normalize subnormal significands and form the product exponent.
// ----------------------------------------------------------------------------
module bq128_unpack (
  input  logic              clk_i,
  input  logic [1:0]        en_i,
  input  logic [63:0]       x_hi_i,
  input  logic [63:0]       x_lo_i,
  input  logic [63:0]       y_hi_i,
  input  logic [63:0]       y_lo_i,
  output bq128_pkg::op_t    op_o
);
  import bq128_pkg::*;

  typedef struct packed {
    logic [127:0] w;
    logic [6:0]   cnt;
  } norm_t;

  // Left-normalize by 64, 32, 16
  function automatic norm_t norm_coarse(norm_t n);
    norm_t r;
    r = n;
    if (r.w[127:64] == 64'd0) begin
      r.w = {r.w[63:0], 64'd0}; r.cnt = r.cnt + 7'd64;
    end
    if (r.w[127:96] == 32'd0) begin
      r.w = {r.w[95:0], 32'd0}; r.cnt = r.cnt + 7'd32;
    end
    if (r.w[127:112] == 16'd0) begin
      r.w = {r.w[111:0], 16'd0}; r.cnt = r.cnt + 7'd16;
    end
    return r;
  endfunction

  // Left-normalize by 8, 4, 2, 1
  function automatic norm_t norm_fine(norm_t n);
    norm_t r;
    r = n;
    if (r.w[127:120] == 8'd0) begin
      r.w = {r.w[119:0], 8'd0}; r.cnt = r.cnt + 7'd8;
    end
    if (r.w[127:124] == 4'd0) begin
      r.w = {r.w[123:0], 4'd0}; r.cnt = r.cnt + 7'd4;
    end
    if (r.w[127:126] == 2'd0) begin
      r.w = {r.w[125:0], 2'd0}; r.cnt = r.cnt + 7'd2;
    end
    if (!r.w[127]) begin
      r.w = {r.w[126:0], 1'b0}; r.cnt = r.cnt + 7'd1;
    end
    return r;
  endfunction

  logic [14:0] ex, ey;
  logic        xfz, yfz, xnan, ynan, xsnan, ysnan, xinf, yinf, xzero, yzero;
  logic        sign;
  ctl_t        ctl_d, ctl_q;
  norm_t       na_d, nb_d, na_q, nb_q, na_f, nb_f;
  logic [14:0] effa_d, effb_d, effa_q, effb_q;
  op_t         op_d, op_q;
  logic signed [EXP_W-1:0] ea, eb;

  // Stage 1: classify and coarse normalize
  always_comb begin
    ex    = x_hi_i[62:48];
    ey    = y_hi_i[62:48];
    sign  = x_hi_i[63] ^ y_hi_i[63];
    xfz   = (x_hi_i[47:0] == 48'd0) && (x_lo_i == 64'd0);
    yfz   = (y_hi_i[47:0] == 48'd0) && (y_lo_i == 64'd0);
    xnan  = (ex == EXP_MAX) && !xfz;
    ynan  = (ey == EXP_MAX) && !yfz;
    xsnan = xnan && !x_hi_i[47];
    ysnan = ynan && !y_hi_i[47];
    xinf  = (ex == EXP_MAX) && xfz;
    yinf  = (ey == EXP_MAX) && yfz;
    xzero = (ex == 15'd0) && xfz;
    yzero = (ey == 15'd0) && yfz;

    ctl_d         = '0;
    ctl_d.sign    = sign;
    ctl_d.special = 1'b1;
    if (xnan) begin
      ctl_d.hi  = x_hi_i | 64'h0000_8000_0000_0000;
      ctl_d.lo  = x_lo_i;
      ctl_d.inv = xsnan || ysnan;
    end else if (ynan) begin
      ctl_d.hi  = y_hi_i | 64'h0000_8000_0000_0000;
      ctl_d.lo  = y_lo_i;
      ctl_d.inv = ysnan;
    end else if (xinf || yinf) begin
      if (xzero || yzero) begin
        ctl_d.hi  = 64'h7FFF_8000_0000_0000;
        ctl_d.inv = 1'b1;
      end else begin
        ctl_d.hi = {sign, EXP_MAX, 48'd0};
      end
    end else if (xzero || yzero) begin
      ctl_d.hi = {sign, 63'd0};
    end else begin
      ctl_d.special = 1'b0;
    end

    na_d   = norm_coarse('{w: {ex != 15'd0, x_hi_i[47:0], x_lo_i, 15'd0}, cnt: 7'd0});
    nb_d   = norm_coarse('{w: {ey != 15'd0, y_hi_i[47:0], y_lo_i, 15'd0}, cnt: 7'd0});
    effa_d = (ex == 15'd0) ? 15'd1 : ex;
    effb_d = (ey == 15'd0) ? 15'd1 : ey;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ctl_q  <= ctl_d;
      na_q   <= na_d;
      nb_q   <= nb_d;
      effa_q <= effa_d;
      effb_q <= effb_d;
    end
  end

  // Stage 2: fine normalize, sum the unbiased exponents
  always_comb begin
    na_f     = norm_fine(na_q);
    nb_f     = norm_fine(nb_q);
    ea       = $signed({3'd0, effa_q}) - EXP_BIAS_S - $signed({11'd0, na_f.cnt});
    eb       = $signed({3'd0, effb_q}) - EXP_BIAS_S - $signed({11'd0, nb_f.cnt});
    op_d.ctl = ctl_q;
    op_d.ma  = na_f.w[127:15];
    op_d.mb  = nb_f.w[127:15];
    op_d.e   = ea + eb;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      op_q <= op_d;
    end
  end

  assign op_o = op_q;

endmodule

@@ rtl/bq128_mant_mul.sv @@
// ----------------------------------------------------------------------------
// bq128_mant_mul
// 113 x 113 significand multiply: sixteen 32x32 partial products, then a
// registered adder tree over four stages.
// ----------------------------------------------------------------------------
module bq128_mant_mul (
  input  logic                               clk_i,
  input  logic [4:0]                         en_i,
  input  bq128_pkg::op_t                     op_i,
  output logic [bq128_pkg::PROD_W-1:0]       prod_o,
  output bq128_pkg::ctl_t                    ctl_o,
  output logic signed [bq128_pkg::EXP_W-1:0] e_o
);
  import bq128_pkg::*;

  logic [127:0] am, bm;
  logic [63:0]  pp_d [4][4];
  logic [63:0]  pp_q [4][4];
  logic [95:0]  s2_d [4][2];
  logic [95:0]  s2_q [4][2];
  logic [159:0] r_d  [4];
  logic [159:0] r_q  [4];
  logic [191:0] h_d  [2];
  logic [191:0] h_q  [2];
  logic [255:0] p_full;
  logic [PROD_W-1:0] p_q;

  ctl_t                    ctl_q [5];
  logic signed [EXP_W-1:0] e_q   [5];

  always_comb begin
    am = {15'd0, op_i.ma};
    bm = {15'd0, op_i.mb};
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pp_d[i][j] = am[32*i +: 32] * bm[32*j +: 32];
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 2; k++) begin
        s2_d[i][k] = {32'd0, pp_q[i][2*k]} + {pp_q[i][2*k+1], 32'd0};
      end
    end
    for (int i = 0; i < 4; i++) begin
      r_d[i] = {64'd0, s2_q[i][0]} + {s2_q[i][1], 64'd0};
    end
    h_d[0] = {32'd0, r_q[0]} + {r_q[1], 32'd0};
    h_d[1] = {32'd0, r_q[2]} + {r_q[3], 32'd0};
    p_full = {64'd0, h_q[0]} + {h_q[1], 64'd0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp_q     <= pp_d;
      ctl_q[0] <= op_i.ctl;
      e_q[0]   <= op_i.e;
    end
    if (en_i[1]) begin
      s2_q     <= s2_d;
      ctl_q[1] <= ctl_q[0];
      e_q[1]   <= e_q[0];
    end
    if (en_i[2]) begin
      r_q      <= r_d;
      ctl_q[2] <= ctl_q[1];
      e_q[2]   <= e_q[1];
    end
    if (en_i[3]) begin
      h_q      <= h_d;
      ctl_q[3] <= ctl_q[2];
      e_q[3]   <= e_q[2];
    end
    if (en_i[4]) begin
      p_q      <= p_full[PROD_W-1:0];
      ctl_q[4] <= ctl_q[3];
      e_q[4]   <= e_q[3];
    end
  end

  assign prod_o = p_q;
  assign ctl_o  = ctl_q[4];
  assign e_o    = e_q[4];

endmodule

@@ rtl/bq128_round.sv @@
// ----------------------------------------------------------------------------
// bq128_round
// Three stages: pick the rounding position, align and gather sticky bits,
// then increment, renormalize and pack with overflow and special handling.
// ----------------------------------------------------------------------------
module bq128_round (
  input  logic                               clk_i,
  input  logic [2:0]                         en_i,
  input  bq128_pkg::rmode_e                  mode_i,
  input  logic [bq128_pkg::PROD_W-1:0]       prod_i,
  input  bq128_pkg::ctl_t                    ctl_i,
  input  logic signed [bq128_pkg::EXP_W-1:0] e_i,
  output bq128_pkg::res_t                    res_o
);
  import bq128_pkg::*;

  // Stage 1
  logic                    lead;
  logic signed [EXP_W-1:0] e2_d, extra;
  logic                    ofl0_d, sub_d, ext1_d;
  logic [8:0]              s_sum;
  logic [7:0]              s_d;

  logic [PROD_W-1:0]       p1_q;
  logic signed [EXP_W-1:0] e2_1_q;
  logic                    ofl0_1_q, sub_1_q, ext1_q;
  logic [7:0]              s_q;
  ctl_t                    ctl1_q;

  always_comb begin
    lead   = prod_i[PROD_W-1];
    e2_d   = e_i + $signed({{(EXP_W-1){1'b0}}, lead});
    ofl0_d = e2_d > EXP_BIAS_S;
    sub_d  = e2_d < EXP_MIN_S;
    extra  = EXP_MIN_S - e2_d;
    ext1_d = sub_d && (extra == 18'sd1);
    s_sum  = 9'd112 + {8'd0, lead} + extra[8:0];
    if (!sub_d) begin
      s_d = 8'd112 + {7'd0, lead};
    end else if (extra > 18'sd200) begin
      s_d = 8'd240;
    end else if (s_sum > 9'd240) begin
      s_d = 8'd240;
    end else begin
      s_d = s_sum[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p1_q     <= prod_i;
      e2_1_q   <= e2_d;
      ofl0_1_q <= ofl0_d;
      sub_1_q  <= sub_d;
      ext1_q   <= ext1_d;
      s_q      <= s_d;
      ctl1_q   <= ctl_i;
    end
  end

  // Stage 2
  logic [255:0]      pw, sh, below;
  logic [7:0]        sm1;
  logic [113:0]      q_d;
  logic              rbit_d, sticky_d, inx_d, tiny_d;
  logic              lead1, rbit0, sticky0, carry0;
  logic [112:0]      q0;

  logic [113:0]            q_q;
  logic                    rbit_q, sticky_q, inx_q, tiny_q;
  logic signed [EXP_W-1:0] e2_2_q;
  logic                    ofl0_2_q, sub_2_q;
  ctl_t                    ctl2_q;

  always_comb begin
    pw       = {30'd0, p1_q};
    sh       = pw >> s_q;
    q_d      = sh[113:0];
    sm1      = s_q - 8'd1;
    below    = pw & ~({256{1'b1}} << s_q);
    inx_d    = |below;
    rbit_d   = pw[sm1];
    sticky_d = |(below & ~(256'd1 << sm1));
    // Round once at the normal position to see whether a value just
    // below the normal range would carry into it.
    lead1    = p1_q[PROD_W-1];
    q0       = lead1 ? p1_q[225:113] : p1_q[224:112];
    rbit0    = lead1 ? p1_q[112] : p1_q[111];
    sticky0  = lead1 ? (|p1_q[111:0]) : (|p1_q[110:0]);
    carry0   = (&q0) && round_inc(mode_i, ctl1_q.sign, rbit0, sticky0, q0[0]);
    tiny_d   = !(ext1_q && carry0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q_q      <= q_d;
      rbit_q   <= rbit_d;
      sticky_q <= sticky_d;
      inx_q    <= inx_d;
      tiny_q   <= tiny_d;
      e2_2_q   <= e2_1_q;
      ofl0_2_q <= ofl0_1_q;
      sub_2_q  <= sub_1_q;
      ctl2_q   <= ctl1_q;
    end
  end

  // Stage 3
  logic                    inc;
  logic [113:0]            qr;
  logic [112:0]            mant;
  logic signed [EXP_W-1:0] e3, ebias;
  logic                    ofl, to_max;
  res_t                    res_d, res_q;

  always_comb begin
    inc    = round_inc(mode_i, ctl2_q.sign, rbit_q, sticky_q, q_q[0]);
    qr     = q_q + {113'd0, inc};
    if (qr[113]) begin
      mant = qr[113:1];
      e3   = e2_2_q + 18'sd1;
    end else begin
      mant = qr[112:0];
      e3   = e2_2_q;
    end
    ebias  = e3 + EXP_BIAS_S;
    ofl    = ofl0_2_q || (!sub_2_q && (e3 > EXP_BIAS_S));
    to_max = (mode_i == RM_RTZ) || ((mode_i == RM_RUP) && ctl2_q.sign) ||
             ((mode_i == RM_RDN) && !ctl2_q.sign);

    res_d = '0;
    if (ctl2_q.special) begin
      res_d.hi  = ctl2_q.hi;
      res_d.lo  = ctl2_q.lo;
      res_d.inv = ctl2_q.inv;
    end else if (ofl) begin
      res_d.ovf = 1'b1;
      res_d.inx = 1'b1;
      if (to_max) begin
        res_d.hi = {ctl2_q.sign, 15'h7FFE, 48'hFFFF_FFFF_FFFF};
        res_d.lo = 64'hFFFF_FFFF_FFFF_FFFF;
      end else begin
        res_d.hi = {ctl2_q.sign, EXP_MAX, 48'd0};
      end
    end else if (sub_2_q) begin
      res_d.hi  = {ctl2_q.sign, 14'd0, qr[112:64]};
      res_d.lo  = qr[63:0];
      res_d.inx = inx_q;
      res_d.unf = tiny_q && inx_q;
    end else begin
      res_d.hi  = {ctl2_q.sign, ebias[14:0], mant[111:64]};
      res_d.lo  = mant[63:0];
      res_d.inx = inx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ verif/binary128_multiplier_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary128_multiplier_top_tb
// Self-checking bench for the binary128 multiplier pipeline.
// ----------------------------------------------------------------------------
// A directed table of corner operands runs first (signed zeros, infinities,
// quiet and signaling NaNs on either side, overflow, total underflow,
// subnormal results), then random operand pairs are pushed under every
// rounding mode. Each accepted beat is run through a bit-accurate product
// calculator in this file and the expectation is queued; each result beat is
// compared field by field with the oldest queued product. Both channels idle
// at random, and the result side holds off once for a long stretch so the
// pipeline fills and backs up into the operand channel.
// ----------------------------------------------------------------------------
module binary128_multiplier_top_tb;
  import bq128_pkg::*;

  localparam int unsigned PIPE_LAT   = 12;   // ten stages plus margin
  localparam int unsigned RAND_BEATS = 270;  // per rounding mode
  localparam int unsigned HOLD_BEAT  = 150;  // result beat that starts the hold
  localparam int unsigned HOLD_LEN   = 400;

  typedef struct {
    logic [127:0] x;
    logic [127:0] y;
    logic         typed;  // expected product written below
    res_t         res;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_mode = 2'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] x_hi = '0, x_lo = '0, y_hi = '0, y_lo = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] product_hi, product_lo;
  logic        flag_invalid, flag_overflow, flag_underflow, flag_inexact;

  rmode_e      cur_mode = RM_RNE;
  res_t        pending_products[$];
  int unsigned n_sent = 0, n_checked = 0, n_errors = 0;
  int unsigned n_ovf = 0, n_unf = 0, n_inv = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("timeout at %0t", $realtime);
    $display("binary128_multiplier_top_tb: errors");
    $finish;
  end

  binary128_multiplier_top u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_rounding_mode_i (cfg_mode),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .x_hi_i              (x_hi),
    .x_lo_i              (x_lo),
    .y_hi_i              (y_hi),
    .y_lo_i              (y_lo),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .product_hi_o        (product_hi),
    .product_lo_o        (product_lo),
    .flag_invalid_o      (flag_invalid),
    .flag_overflow_o     (flag_overflow),
    .flag_underflow_o    (flag_underflow),
    .flag_inexact_o      (flag_inexact)
  );

  // --------------------------------------------------------------------------
  // Product calculator
  // --------------------------------------------------------------------------

  // Shift the exact product right by sh and round to an integer.
  function automatic void round_shifted(input logic [255:0] p, input int unsigned sh,
                                        input rmode_e m, input logic sg,
                                        output logic [127:0] q, output logic lost);
    logic [255:0] shifted, mask;
    logic         rbit, sticky, bump;
    shifted = p >> sh;
    q       = shifted[127:0];
    rbit    = (sh >= 1) ? p[sh-1] : 1'b0;
    mask    = (sh >= 2) ? ((256'd1 << (sh - 1)) - 256'd1) : '0;
    sticky  = |(p & mask);
    lost    = rbit | sticky;
    case (m)
      RM_RNE:  bump = rbit && (sticky || q[0]);
      RM_RTZ:  bump = 1'b0;
      RM_RUP:  bump = lost && !sg;
      default: bump = lost && sg;
    endcase
    if (bump) q = q + 128'd1;
  endfunction

  // Significand with the leading one at bit 112, and unbiased exponent.
  function automatic void normalize(input logic [127:0] v, output logic [112:0] m,
                                    output int e);
    if (v[126:112] != 15'd0) begin
      m = {1'b1, v[111:0]};
      e = int'(v[126:112]) - 16383;
    end else begin
      m = {1'b0, v[111:0]};
      e = -16382;
      while (!m[112]) begin
        m = m << 1;
        e = e - 1;
      end
    end
  endfunction

  function automatic res_t mul_product(logic [127:0] x, logic [127:0] y, rmode_e m);
    res_t         r;
    logic         sg, xnan, ynan, xsig, ysig, xinf, yinf, xzero, yzero, ofl, lost, tiny;
    logic [112:0] ma, mb;
    logic [255:0] p;
    logic [127:0] q;
    int           ea, eb, e, extra;
    int unsigned  lead, sh;
    r     = '0;
    ofl   = 1'b0;
    sg    = x[127] ^ y[127];
    xnan  = x[126:112] == EXP_MAX && x[111:0] != '0;
    ynan  = y[126:112] == EXP_MAX && y[111:0] != '0;
    xsig  = xnan && !x[111];
    ysig  = ynan && !y[111];
    xinf  = x[126:112] == EXP_MAX && x[111:0] == '0;
    yinf  = y[126:112] == EXP_MAX && y[111:0] == '0;
    xzero = x[126:0] == '0;
    yzero = y[126:0] == '0;
    if (xnan) begin
      {r.hi, r.lo} = x | (128'd1 << 111);
      r.inv = xsig || ysig;
    end else if (ynan) begin
      {r.hi, r.lo} = y | (128'd1 << 111);
      r.inv = ysig;
    end else if (xinf || yinf) begin
      if (xzero || yzero) begin
        r.hi  = 64'h7FFF_8000_0000_0000;
        r.inv = 1'b1;
      end else begin
        r.hi = {sg, EXP_MAX, 48'd0};
      end
    end else if (xzero || yzero) begin
      r.hi = {sg, 63'd0};
    end else begin
      normalize(x, ma, ea);
      normalize(y, mb, eb);
      p    = 256'(ma) * 256'(mb);
      lead = p[225] ? 225 : 224;
      e    = ea + eb + int'(lead) - 224;
      if (e > 16383) begin
        ofl = 1'b1;
      end else if (e >= -16382) begin
        round_shifted(p, lead - 112, m, sg, q, lost);
        if (q[113]) begin
          q = q >> 1;
          e = e + 1;
        end
        if (e > 16383) begin
          ofl = 1'b1;
        end else begin
          r.hi  = {sg, 15'(e + 16383), q[111:64]};
          r.lo  = q[63:0];
          r.inx = lost;
        end
      end else begin
        // tininess is judged on the result rounded with unbounded exponent
        extra = -16382 - e;
        round_shifted(p, lead - 112, m, sg, q, lost);
        tiny = !(e == -16383 && q[113]);
        sh   = (extra > 200) ? 240 : lead - 112 + extra;
        if (sh > 240) sh = 240;
        round_shifted(p, sh, m, sg, q, lost);
        r.hi  = {sg, 14'd0, q[112:64]};
        r.lo  = q[63:0];
        r.inx = lost;
        r.unf = tiny && lost;
      end
      if (ofl) begin
        r.ovf = 1'b1;
        r.inx = 1'b1;
        if (m == RM_RTZ || (m == RM_RUP && sg) || (m == RM_RDN && !sg)) begin
          r.hi = {sg, 63'h7FFE_FFFF_FFFF_FFFF};
          r.lo = '1;
        end else begin
          r.hi = {sg, EXP_MAX, 48'd0};
          r.lo = '0;
        end
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Operand side
  // --------------------------------------------------------------------------
  logic drv_idle_on = 1'b0;

  // Offer one beat, hold it until taken, queue its product, then maybe gap.
  task automatic send_operands(logic [127:0] x, logic [127:0] y, logic typed, res_t res);
    int unsigned gap;
    in_valid <= 1'b1;
    {x_hi, x_lo} <= x;
    {y_hi, y_lo} <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_products.push_back(typed ? res : mul_product(x, y, cur_mode));
    n_sent++;
    if (n_sent % 64 == 0) drv_idle_on = ($urandom_range(0, 2) != 0);
    gap = drv_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_mode(rmode_e m);
    cfg_valid <= 1'b1;
    cfg_mode  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_mode = m;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [127:0] pack_operand(logic sg, logic [14:0] ex);
    logic [127:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       v[111:0] = '1;  // forces carries through rounding
      1:       v[111:0] = '0;
      default: ;
    endcase
    v[127]     = sg;
    v[126:112] = ex;
    return v;
  endfunction

  // Draw an operand pair aimed at one region of the result space.
  task automatic pick_pair(output logic [127:0] x, output logic [127:0] y);
    int ex, ey;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: begin  // results in the normal range
        ex = 16383 + $urandom_range(0, 160) - 80;
        ey = 16383 + $urandom_range(0, 160) - 80;
      end
      4, 5: begin        // around the subnormal boundary
        ex = $urandom_range(1, 32766);
        ey = 16384 - ex - $urandom_range(0, 130) + 2;
      end
      6: begin           // around the overflow boundary
        ex = $urandom_range(16400, 32766);
        ey = 49149 - ex + $urandom_range(0, 3) - 2;
      end
      7: begin           // subnormal operand against a wide exponent
        ex = 0;
        ey = $urandom_range(0, 32766);
      end
      8: begin           // specials mixed with anything
        ex = $urandom_range(0, 1) ? 32767 : 0;
        ey = $urandom_range(0, 32767);
      end
      default: begin     // raw bit patterns
        x = {$urandom, $urandom, $urandom, $urandom};
        y = {$urandom, $urandom, $urandom, $urandom};
        return;
      end
    endcase
    if (ey < 0) ey = 0;
    if (ey > 32766) ey = 32766;
    x = pack_operand($urandom_range(0, 1), 15'(ex));
    y = pack_operand($urandom_range(0, 1), 15'(ey));
    if ($urandom_range(0, 1)) {x, y} = {y, x};
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  initial begin
    int unsigned beats, stall;
    logic        rcv_idle_on;
    beats       = 0;
    rcv_idle_on = 1'b0;
    @(posedge rst_n);
    forever begin
      if (beats == HOLD_BEAT) begin
        // long hold-off: the pipe fills and in_ready must drop
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        if (beats % 50 == 0) rcv_idle_on = ($urandom_range(0, 2) != 0);
        stall = rcv_idle_on ? $urandom_range(0, 19) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats++;
    end
  end

  // Compare every result beat with the oldest queued product.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_products.size() == 0) begin
        $display("%0t: result beat with nothing pending hi=%h lo=%h", $realtime,
                 product_hi, product_lo);
        n_errors++;
      end else begin
        want = pending_products.pop_front();
        n_checked++;
        if (want.ovf) n_ovf++;
        if (want.unf) n_unf++;
        if (want.inv) n_inv++;
        if (product_hi !== want.hi) begin
          $display("%0t: product_hi expected %h actual %h", $realtime, want.hi, product_hi);
          n_errors++;
        end
        if (product_lo !== want.lo) begin
          $display("%0t: product_lo expected %h actual %h", $realtime, want.lo, product_lo);
          n_errors++;
        end
        if (flag_invalid !== want.inv) begin
          $display("%0t: flag_invalid expected %b actual %b", $realtime, want.inv,
                   flag_invalid);
          n_errors++;
        end
        if (flag_overflow !== want.ovf) begin
          $display("%0t: flag_overflow expected %b actual %b", $realtime, want.ovf,
                   flag_overflow);
          n_errors++;
        end
        if (flag_underflow !== want.unf) begin
          $display("%0t: flag_underflow expected %b actual %b", $realtime, want.unf,
                   flag_underflow);
          n_errors++;
        end
        if (flag_inexact !== want.inx) begin
          $display("%0t: flag_inexact expected %b actual %b", $realtime, want.inx,
                   flag_inexact);
          n_errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  localparam logic [127:0] ONE     = {64'h3FFF_0000_0000_0000, 64'd0};
  localparam logic [127:0] TWO_NEG = {64'hC000_0000_0000_0000, 64'd0};
  localparam logic [127:0] HALF    = {64'h3FFE_0000_0000_0000, 64'd0};
  localparam logic [127:0] PZERO   = '0;
  localparam logic [127:0] NZERO   = {1'b1, 127'd0};
  localparam logic [127:0] PINF    = {64'h7FFF_0000_0000_0000, 64'd0};
  localparam logic [127:0] SNAN    = {64'h7FFF_0000_0000_0000, 64'd1};
  localparam logic [127:0] QNAN    = {64'hFFFF_8000_0000_1234, 64'd5};
  localparam logic [127:0] MAXF    = {64'h7FFE_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
  localparam logic [127:0] MINSUB  = {64'd0, 64'd1};
  localparam logic [127:0] MINNORM = {64'h0001_0000_0000_0000, 64'd0};
  localparam logic [127:0] ALLONE  = '1;
  localparam logic [127:0] NEARMIN = {64'h3FFE_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};

  vec_t corner_vectors[$];

  function automatic res_t mk(logic [63:0] hi, logic [63:0] lo, logic [3:0] flags);
    res_t r;
    r.hi = hi;
    r.lo = lo;
    {r.inv, r.ovf, r.unf, r.inx} = flags;
    return r;
  endfunction

  initial begin
    logic [127:0] x, y;
    rmode_e       modes[4];
    modes = '{RM_RTZ, RM_RUP, RM_RDN, RM_RNE};

    // flags column is {invalid, overflow, underflow, inexact}
    corner_vectors = '{
      '{ONE, ONE, 1'b1, mk(64'h3FFF_0000_0000_0000, 64'd0, 4'b0000)},
      '{PZERO, NZERO, 1'b1, mk(64'h8000_0000_0000_0000, 64'd0, 4'b0000)},
      '{PINF, PZERO, 1'b1, mk(64'h7FFF_8000_0000_0000, 64'd0, 4'b1000)},
      '{NZERO, PINF, 1'b1, mk(64'h7FFF_8000_0000_0000, 64'd0, 4'b1000)},
      '{PINF, TWO_NEG, 1'b1, mk(64'hFFFF_0000_0000_0000, 64'd0, 4'b0000)},
      '{SNAN, ONE, 1'b1, mk(64'h7FFF_8000_0000_0000, 64'd1, 4'b1000)},
      '{QNAN, SNAN, 1'b1, mk(64'hFFFF_8000_0000_1234, 64'd5, 4'b1000)},
      '{ONE, SNAN, 1'b1, mk(64'h7FFF_8000_0000_0000, 64'd1, 4'b1000)},
      '{ONE, QNAN, 1'b1, mk(64'hFFFF_8000_0000_1234, 64'd5, 4'b0000)},
      '{PINF, QNAN, 1'b1, mk(64'hFFFF_8000_0000_1234, 64'd5, 4'b0000)},
      '{MAXF, MAXF, 1'b1, mk(64'h7FFF_0000_0000_0000, 64'd0, 4'b0101)},
      '{MINSUB, MINSUB, 1'b1, mk(64'd0, 64'd0, 4'b0011)},
      '{ALLONE, ALLONE, 1'b0, '0},
      '{PZERO, PZERO, 1'b0, '0},
      '{MINNORM, HALF, 1'b0, '0},
      '{MINNORM, NEARMIN, 1'b0, '0},
      '{MINSUB, MAXF, 1'b0, '0},
      '{MAXF, HALF, 1'b0, '0},
      '{MAXF, NEARMIN, 1'b0, '0},
      '{{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
        {64'h2AAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555}, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(RM_RNE);
    foreach (corner_vectors[i])
      send_operands(corner_vectors[i].x, corner_vectors[i].y, corner_vectors[i].typed,
                    corner_vectors[i].res);
    drain();

    // random pairs under each mode; the corner rows are replayed at each
    // mode too, predicted rather than typed
    foreach (modes[k]) begin
      write_mode(modes[k]);
      foreach (corner_vectors[i])
        send_operands(corner_vectors[i].x, corner_vectors[i].y, 1'b0, '0);
      repeat (RAND_BEATS) begin
        pick_pair(x, y);
        send_operands(x, y, 1'b0, '0);
      end
      drain();
    end

    $display("%0d operand beats, %0d results checked in all four rounding modes",
             n_sent, n_checked);
    $display("overflow %0d, underflow %0d, invalid %0d, mismatches %0d",
             n_ovf, n_unf, n_inv, n_errors);
    if (n_errors == 0) begin
      $display("binary128_multiplier_top_tb: clean");
    end else begin
      $display("binary128_multiplier_top_tb: errors");
    end
    $finish;
  end

endmodule
